// ===== hw/rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, constants and helpers for the build script tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

    localparam int MAX_TOKEN = 8192;
    localparam int LEN_W     = 14;

    localparam logic [LEN_W-1:0] CNT_LIMIT   = LEN_W'(MAX_TOKEN - 1);
    localparam logic [LEN_W-1:0] DEPTH_LIMIT = '1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ACTION = 2'd1;
    localparam logic [1:0] MODE_PUNCT  = 2'd2;

    localparam logic TYPE_WORD   = 1'b0;
    localparam logic TYPE_ACTION = 1'b1;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_COMMENT = 2'd1,
        PH_WORD    = 2'd2,
        PH_ACTION  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_EOI   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_ACTION_BIG = 2'd0,
        ERR_BRACE      = 2'd1,
        ERR_WORD_BIG   = 2'd2,
        ERR_QUOTE      = 2'd3
    } t_err;

    typedef struct packed {
        t_phase           phase;
        logic             in_quote;
        logic             escape_pending;
        logic             not_keyword;
        logic             first_is_letter;
        logic [1:0]       active_mode;
        logic [LEN_W-1:0] brace_depth;
        logic [LEN_W-1:0] byte_count;
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       token_byte;
        logic             token_type;
        logic             keyword_candidate;
        logic [LEN_W-1:0] token_length;
        t_err             error_code;
        logic             last;
    } t_result;

    function automatic t_state f_clear(logic [1:0] mode);
        t_state s;
        s.phase           = PH_START;
        s.in_quote        = 1'b0;
        s.escape_pending  = 1'b0;
        s.not_keyword     = 1'b0;
        s.first_is_letter = 1'b0;
        s.active_mode     = mode;
        s.brace_depth     = LEN_W'(1);
        s.byte_count      = '0;
        return s;
    endfunction

    function automatic logic f_is_space(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic f_is_alpha(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bst_if.sv =====
// ----------------------------------------------------------------------------
// bst_if
// Valid/ready channels for source characters and tokenizer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;
    logic [1:0] scan_mode;

    modport source (output valid, char_code, end_of_input, scan_mode, input ready);
    modport sink   (input valid, char_code, end_of_input, scan_mode, output ready);
endinterface

interface bst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  token_byte;
    logic        token_type;
    logic        keyword_candidate;
    logic [13:0] token_length;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, result_kind, token_byte, token_type, keyword_candidate,
                    token_length, error_code, last, input ready);
    modport sink   (input valid, result_kind, token_byte, token_type, keyword_candidate,
                    token_length, error_code, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bst_step.sv =====
// ----------------------------------------------------------------------------
// bst_step
// Next-state and result logic for one character or end of input.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_step import bst_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_input,
    input  logic [1:0] i_scan_mode,
    output t_state     o_state,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_res_cnt
);

    typedef struct packed {
        t_state st;
        logic   byte_out;
        logic   tok_end;
    } t_start;

    typedef struct packed {
        t_state  st;
        t_result res;
    } t_emit;

    function automatic t_result f_byte(logic [7:0] c);
        t_result r;
        r            = '0;
        r.kind       = KIND_BYTE;
        r.token_byte = c;
        return r;
    endfunction

    function automatic t_result f_end(logic ty, logic kw, logic [LEN_W-1:0] len);
        t_result r;
        r                   = '0;
        r.kind              = KIND_END;
        r.token_type        = ty;
        r.keyword_candidate = kw;
        r.token_length      = len;
        return r;
    endfunction

    function automatic t_result f_err(t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic t_result f_eoi();
        t_result r;
        r      = '0;
        r.kind = KIND_EOI;
        return r;
    endfunction

    function automatic logic f_kw(t_state s);
        return !s.not_keyword && !(s.first_is_letter && s.active_mode == MODE_PUNCT);
    endfunction

    function automatic t_emit f_emit(t_state s, logic [7:0] c, t_err code);
        t_emit e;
        e.st = s;
        if (s.byte_count >= CNT_LIMIT) begin
            e.res = f_err(code);
            e.st  = f_clear(s.active_mode);
        end else begin
            e.res           = f_byte(c);
            e.st.byte_count = s.byte_count + LEN_W'(1);
        end
        return e;
    endfunction

    // token start; a handed-on closing brace in action mode is dropped
    function automatic t_start f_start(t_state s, logic [7:0] c, logic [1:0] mode,
                                       logic handed);
        t_start r;
        r.st       = s;
        r.byte_out = 1'b0;
        r.tok_end  = 1'b0;
        if (mode == MODE_ACTION) begin
            if (!(handed && c == CH_RBRACE)) begin
                r.st.active_mode = MODE_ACTION;
                r.st.phase       = PH_ACTION;
                r.st.brace_depth = LEN_W'(1);
                r.st.byte_count  = '0;
                if (c == CH_RBRACE) begin
                    r.tok_end = 1'b1;
                    r.st      = f_clear(MODE_ACTION);
                end else begin
                    if (c == CH_LBRACE) begin
                        r.st.brace_depth = LEN_W'(2);
                    end
                    r.byte_out      = 1'b1;
                    r.st.byte_count = LEN_W'(1);
                end
            end
        end else begin
            r.st.active_mode = mode;
            if (c == CH_HASH) begin
                r.st.phase = PH_COMMENT;
            end else if (!f_is_space(c)) begin
                r.st.phase           = PH_WORD;
                r.st.in_quote        = 1'b0;
                r.st.escape_pending  = 1'b0;
                r.st.byte_count      = '0;
                r.st.not_keyword     = (c == CH_DOLLAR);
                r.st.first_is_letter = f_is_alpha(c);
                if (c == CH_QUOTE) begin
                    r.st.in_quote    = 1'b1;
                    r.st.not_keyword = 1'b1;
                end else if (c == CH_BSLASH) begin
                    r.st.escape_pending = 1'b1;
                end else begin
                    r.byte_out      = 1'b1;
                    r.st.byte_count = LEN_W'(1);
                end
            end
        end
        return r;
    endfunction

    t_state           v_s;
    t_start           v_start;
    t_emit            v_emit;
    t_result          v_r0;
    t_result          v_r1;
    logic [1:0]       v_n;
    logic             v_hand;
    logic [LEN_W-1:0] v_depth;

    always_comb begin
        v_s     = i_state;
        v_start = '0;
        v_emit  = '0;
        v_r0    = '0;
        v_r1    = '0;
        v_n     = 2'd0;
        v_hand  = 1'b0;
        v_depth = '0;
        if (i_end_of_input) begin
            v_s = f_clear(MODE_NORMAL);
            if ((i_state.phase == PH_START && i_scan_mode == MODE_ACTION) ||
                i_state.phase == PH_ACTION) begin
                v_r0 = f_err(ERR_BRACE);
                v_r1 = f_eoi();
                v_n  = 2'd2;
            end else if (i_state.phase == PH_WORD) begin
                v_r0 = i_state.in_quote ? f_err(ERR_QUOTE)
                                        : f_end(TYPE_WORD, f_kw(i_state), i_state.byte_count);
                v_r1 = f_eoi();
                v_n  = 2'd2;
            end else begin
                v_r0 = f_eoi();
                v_n  = 2'd1;
            end
        end else begin
            unique case (i_state.phase)
                PH_START: begin
                    v_start = f_start(i_state, i_char_code, i_scan_mode, 1'b0);
                    v_s     = v_start.st;
                    if (v_start.tok_end) begin
                        v_r0 = f_end(TYPE_ACTION, 1'b0, '0);
                        v_n  = 2'd1;
                    end else if (v_start.byte_out) begin
                        v_r0 = f_byte(i_char_code);
                        v_n  = 2'd1;
                    end
                end
                PH_COMMENT: begin
                    if (i_char_code == CH_LF) begin
                        v_s.phase = PH_START;
                    end
                end
                PH_WORD: begin
                    if (i_state.escape_pending) begin
                        v_s.escape_pending = 1'b0;
                        v_s.not_keyword    = 1'b1;
                        v_emit             = f_emit(v_s, i_char_code, ERR_WORD_BIG);
                        v_s                = v_emit.st;
                        v_r0               = v_emit.res;
                        v_n                = 2'd1;
                    end else if (!i_state.in_quote && f_is_space(i_char_code)) begin
                        v_r0   = f_end(TYPE_WORD, f_kw(i_state), i_state.byte_count);
                        v_n    = 2'd1;
                        v_s    = f_clear(i_state.active_mode);
                        v_hand = 1'b1;
                    end else if (i_char_code == CH_QUOTE) begin
                        v_s.in_quote    = !i_state.in_quote;
                        v_s.not_keyword = 1'b1;
                    end else if (i_char_code == CH_BSLASH) begin
                        v_s.escape_pending = 1'b1;
                    end else begin
                        v_emit = f_emit(v_s, i_char_code, ERR_WORD_BIG);
                        v_s    = v_emit.st;
                        v_r0   = v_emit.res;
                        v_n    = 2'd1;
                    end
                end
                PH_ACTION: begin
                    if (i_char_code == CH_RBRACE) begin
                        v_depth = (i_state.brace_depth != '0) ?
                                  i_state.brace_depth - LEN_W'(1) : '0;
                    end else if (i_char_code == CH_LBRACE &&
                                 i_state.brace_depth != DEPTH_LIMIT) begin
                        v_depth = i_state.brace_depth + LEN_W'(1);
                    end else begin
                        v_depth = i_state.brace_depth;
                    end
                    if (i_char_code == CH_RBRACE && v_depth == '0) begin
                        v_r0   = f_end(TYPE_ACTION, 1'b0, i_state.byte_count);
                        v_n    = 2'd1;
                        v_s    = f_clear(i_state.active_mode);
                        v_hand = 1'b1;
                    end else begin
                        v_s.brace_depth = v_depth;
                        v_emit          = f_emit(v_s, i_char_code, ERR_ACTION_BIG);
                        v_s             = v_emit.st;
                        v_r0            = v_emit.res;
                        v_n             = 2'd1;
                    end
                end
            endcase
            // terminating character restarts the next token
            if (v_hand) begin
                v_start = f_start(v_s, i_char_code, i_scan_mode, 1'b1);
                v_s     = v_start.st;
                if (v_start.byte_out) begin
                    v_r1 = f_byte(i_char_code);
                    v_n  = 2'd2;
                end
            end
        end
        if (v_n == 2'd1) begin
            v_r0.last = 1'b1;
        end
        if (v_n == 2'd2) begin
            v_r1.last = 1'b1;
        end
    end

    assign o_state   = v_s;
    assign o_res0    = v_r0;
    assign o_res1    = v_r1;
    assign o_res_cnt = v_n;

endmodule

`default_nettype wire

// ===== hw/rtl/bst_outq.sv =====
// ----------------------------------------------------------------------------
// bst_outq
// Four-entry result queue; takes up to two results per cycle, sends one while i_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_outq import bst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_space,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       w_pop;

    assign w_pop   = (r_count != 3'd0) && i_ready;
    assign n_count = r_count + 3'(i_push_cnt) - 3'(w_pop);
    assign o_space = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_cnt;
            r_rd_ptr <= r_rd_ptr + 2'(w_pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/build_script_tokenizer.sv =====
// ----------------------------------------------------------------------------
// build_script_tokenizer
// Splits a character stream into word and action-string tokens.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          per transaction
//  i_in     in   char_code, end_of_input, scan_mode               one character
//  o_out    out  result_kind, token_byte, token_type,             one result,
//                keyword_candidate, token_length, error_code,     0..2 per char
//                last
//
//  One character per cycle while i_in.ready is high: the scanner state is
//  registered and its 0..2 results land in a four-entry result queue.
//  i_in.ready is high while the queue has room for two results.
//  A character producing two results drains as two separate output transfers.
//  Synchronous active-low reset returns the scanner to token start.
// ----------------------------------------------------------------------------
`default_nettype none

module build_script_tokenizer import bst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bst_in_if.sink    i_in,
    bst_out_if.source o_out
);

    t_state     r_state;
    t_state     n_state;
    t_result    w_res0;
    t_result    w_res1;
    t_result    w_qres;
    logic [1:0] w_res_cnt;
    logic [1:0] w_push_cnt;
    logic       w_space;
    logic       w_accept;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;
    assign w_push_cnt = w_accept ? w_res_cnt : 2'd0;

    bst_step u_step (
        .i_state        (r_state),
        .i_char_code    (i_in.char_code),
        .i_end_of_input (i_in.end_of_input),
        .i_scan_mode    (i_in.scan_mode),
        .o_state        (n_state),
        .o_res0         (w_res0),
        .o_res1         (w_res1),
        .o_res_cnt      (w_res_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_clear(MODE_NORMAL);
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    bst_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_space    (w_space),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (w_qres)
    );

    assign o_out.result_kind       = w_qres.kind;
    assign o_out.token_byte        = w_qres.token_byte;
    assign o_out.token_type        = w_qres.token_type;
    assign o_out.keyword_candidate = w_qres.keyword_candidate;
    assign o_out.token_length      = w_qres.token_length;
    assign o_out.error_code        = w_qres.error_code;
    assign o_out.last              = w_qres.last;

endmodule

`default_nettype wire
